@@ rtl/obstacle_avoid_steering_mux_defines.svh @@
// Assertion macros used by the checker file.
`ifndef OBSTACLE_AVOID_STEERING_MUX_DEFINES_SVH
`define OBSTACLE_AVOID_STEERING_MUX_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OASM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define OASM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// Condition that must hold in the cycle after a reset cycle.
`define OASM_ASSERT_RESET(label, clk, rst_n, cons) \
    label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error("reset check failed");

`endif

@@ rtl/oasm_pkg.sv @@
package oasm_pkg;

    localparam int TSQ_W = 30;

    localparam logic [1:0] KIND_MODEL  = 2'd0;
    localparam logic [1:0] KIND_OBJECT = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;

    localparam logic [1:0] MODE_CODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_CODE_AVOID   = 2'd1;
    localparam logic [1:0] MODE_CODE_RECOVER = 2'd2;

    localparam logic [2:0] CFG_TRIGGER       = 3'd0;
    localparam logic [2:0] CFG_WINDOW        = 3'd1;
    localparam logic [2:0] CFG_STEER         = 3'd2;
    localparam logic [2:0] CFG_THROTTLE      = 3'd3;
    localparam logic [2:0] CFG_AVOID_TICKS   = 3'd4;
    localparam logic [2:0] CFG_RECOVER_TICKS = 3'd5;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'b001,
        MODE_AVOID   = 3'b010,
        MODE_RECOVER = 3'b100
    } t_mode;

    typedef struct packed {
        logic [1:0]       kind;
        logic [15:0]      angle;
        logic [15:0]      throttle;
        logic             near;
        logic             side_pos;
        logic             last;
        logic [TSQ_W-1:0] dsq;
    } t_item;

    typedef struct packed {
        logic [14:0]      steer;
        logic [15:0]      throttle;
        logic [15:0]      avoid_ticks;
        logic [15:0]      recover_ticks;
    } t_cfg;

endpackage

@@ rtl/oasm_front.sv @@
module oasm_front import oasm_pkg::*; #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [1:0]             i_kind,
    input  logic [15:0]            i_model_angle,
    input  logic [15:0]            i_model_throttle,
    input  logic [COORD_WIDTH-1:0] i_obj_x_mm,
    input  logic [COORD_WIDTH-1:0] i_obj_y_mm,
    input  logic                   i_last_object,
    input  logic [14:0]            i_window,
    input  logic [TSQ_W-1:0]       i_tsq,
    output logic                   o_q_push,
    output t_item                  o_q_item,
    input  logic                   i_q_full
);

    localparam int SQ_W  = 2 * COORD_WIDTH;
    localparam int SUM_W = SQ_W + 1;
    localparam int CMP_W = (SUM_W > TSQ_W) ? SUM_W : TSQ_W;
    localparam int WIN_W = (COORD_WIDTH > 15) ? COORD_WIDTH : 15;

    logic [COORD_WIDTH-1:0] w_ax;
    logic [COORD_WIDTH-1:0] w_ay;
    logic                   w_keep;
    logic                   w_side_pos;
    logic [SQ_W-1:0]        w_sqx;
    logic [SQ_W-1:0]        w_sqy;
    logic [SUM_W-1:0]       w_sum;
    logic                   w_s2_move;
    logic                   w_s1_move;
    logic                   w_s1_free;
    logic                   w_accept;
    t_item                  w_s2_item;

    logic                   r_s1_valid;
    logic [1:0]             r_s1_kind;
    logic [15:0]            r_s1_angle;
    logic [15:0]            r_s1_throttle;
    logic                   r_s1_keep;
    logic                   r_s1_side_pos;
    logic                   r_s1_last;
    logic [SQ_W-1:0]        r_s1_sqx;
    logic [SQ_W-1:0]        r_s1_sqy;
    logic                   r_s2_valid;
    t_item                  r_s2_item;

    // The object is mirrored, so it lies ahead exactly when the raw x is negative.
    assign w_ax = i_obj_x_mm[COORD_WIDTH-1] ? (~i_obj_x_mm + 1'b1) : i_obj_x_mm;
    assign w_ay = i_obj_y_mm[COORD_WIDTH-1] ? (~i_obj_y_mm + 1'b1) : i_obj_y_mm;
    assign w_keep = i_obj_x_mm[COORD_WIDTH-1] && (WIN_W'(w_ay) <= WIN_W'(i_window));
    assign w_side_pos = i_obj_y_mm[COORD_WIDTH-1] || (i_obj_y_mm == '0);
    assign w_sqx = SQ_W'(w_ax) * SQ_W'(w_ax);
    assign w_sqy = SQ_W'(w_ay) * SQ_W'(w_ay);

    assign w_sum = SUM_W'(r_s1_sqx) + SUM_W'(r_s1_sqy);

    always_comb begin
        w_s2_item          = '0;
        w_s2_item.kind     = r_s1_kind;
        w_s2_item.angle    = r_s1_angle;
        w_s2_item.throttle = r_s1_throttle;
        w_s2_item.near     = r_s1_keep && (CMP_W'(w_sum) < CMP_W'(i_tsq));
        w_s2_item.side_pos = r_s1_side_pos;
        w_s2_item.last     = r_s1_last;
        w_s2_item.dsq      = TSQ_W'(w_sum);
    end

    assign w_s2_move = r_s2_valid && !i_q_full;
    assign w_s1_move = r_s1_valid && (!r_s2_valid || w_s2_move);
    assign w_s1_free = !r_s1_valid || w_s1_move;
    assign w_accept  = push && w_s1_free;
    assign full      = !w_s1_free;
    assign o_q_push  = w_s2_move;
    assign o_q_item  = r_s2_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_move) begin
                r_s2_valid <= 1'b1;
            end else if (w_s2_move) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_kind     <= i_kind;
            r_s1_angle    <= i_model_angle;
            r_s1_throttle <= i_model_throttle;
            r_s1_keep     <= w_keep;
            r_s1_side_pos <= w_side_pos;
            r_s1_last     <= i_last_object;
            r_s1_sqx      <= w_sqx;
            r_s1_sqy      <= w_sqy;
        end
        if (w_s1_move) begin
            r_s2_item <= w_s2_item;
        end
    end

endmodule

@@ rtl/oasm_fifo.sv @@
module oasm_fifo import oasm_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_item    = r_mem[r_rd];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= (r_wr == LAST_IDX) ? '0 : r_wr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd <= (r_rd == LAST_IDX) ? '0 : r_rd + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

@@ rtl/oasm_back.sv @@
module oasm_back import oasm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  t_item              i_q_item,
    output logic               o_q_pop,
    input  t_cfg               i_cfg,
    output logic               empty,
    input  logic               pop,
    output logic signed [15:0] o_cmd_angle,
    output logic signed [15:0] o_cmd_throttle,
    output logic [1:0]         o_mode
);

    t_mode            r_mode;
    logic [15:0]      r_elapsed;
    logic             r_steer_left;
    logic [15:0]      r_cached_angle;
    logic [15:0]      r_cached_throttle;
    logic [TSQ_W-1:0] r_nearest;
    logic             r_side;
    logic             r_found;
    logic             r_out_valid;
    logic [15:0]      r_out_angle;
    logic [15:0]      r_out_throttle;
    logic [1:0]       r_out_mode;

    t_mode            n_mode;
    logic [15:0]      n_elapsed;
    logic             n_steer_left;
    logic [15:0]      n_cached_angle;
    logic [15:0]      n_cached_throttle;
    logic [TSQ_W-1:0] n_nearest;
    logic             n_side;
    logic             n_found;
    logic             n_out_valid;
    logic [15:0]      n_out_angle;
    logic [15:0]      n_out_throttle;
    logic [1:0]       n_out_mode;

    logic             w_out_free;
    logic             w_hit;
    logic [15:0]      w_steer_pos;
    logic [15:0]      w_steer_neg;
    logic [15:0]      w_inc;
    logic [15:0]      w_limit;

    assign w_out_free  = !r_out_valid || pop;
    assign o_q_pop     = !i_q_empty && ((i_q_item.kind != KIND_TICK) || w_out_free);
    assign w_steer_pos = {1'b0, i_cfg.steer};
    assign w_steer_neg = ~w_steer_pos + 16'd1;
    assign w_inc       = (r_elapsed != 16'hFFFF) ? (r_elapsed + 16'd1) : r_elapsed;
    assign w_limit     = (r_mode == MODE_AVOID) ? i_cfg.avoid_ticks : i_cfg.recover_ticks;
    assign w_hit       = i_q_item.near && (!r_found || (i_q_item.dsq < r_nearest));

    assign empty          = !r_out_valid;
    assign o_cmd_angle    = r_out_angle;
    assign o_cmd_throttle = r_out_throttle;
    assign o_mode         = r_out_mode;

    always_comb begin
        n_mode            = r_mode;
        n_elapsed         = r_elapsed;
        n_steer_left      = r_steer_left;
        n_cached_angle    = r_cached_angle;
        n_cached_throttle = r_cached_throttle;
        n_nearest         = r_nearest;
        n_side            = r_side;
        n_found           = r_found;
        n_out_valid       = r_out_valid && !pop;
        n_out_angle       = r_out_angle;
        n_out_throttle    = r_out_throttle;
        n_out_mode        = r_out_mode;
        if (o_q_pop) begin
            case (i_q_item.kind)
                KIND_MODEL: begin
                    n_cached_angle    = i_q_item.angle;
                    n_cached_throttle = i_q_item.throttle;
                end
                KIND_OBJECT: begin
                    if (w_hit) begin
                        n_nearest = i_q_item.dsq;
                        n_side    = i_q_item.side_pos;
                        n_found   = 1'b1;
                    end
                    if (i_q_item.last) begin
                        if ((r_mode == MODE_IDLE) && (r_found || w_hit)) begin
                            n_mode       = MODE_AVOID;
                            n_elapsed    = 16'd0;
                            n_steer_left = w_hit ? i_q_item.side_pos : r_side;
                        end
                        n_found = 1'b0;
                        n_side  = 1'b0;
                    end
                end
                KIND_TICK: begin
                    n_out_valid = 1'b1;
                    case (r_mode)
                        MODE_AVOID, MODE_RECOVER: begin
                            n_out_angle    = (r_mode == MODE_RECOVER) ? 16'd0 :
                                             (r_steer_left ? w_steer_pos : w_steer_neg);
                            n_out_throttle = i_cfg.throttle;
                            n_out_mode     = (r_mode == MODE_AVOID) ? MODE_CODE_AVOID :
                                                                      MODE_CODE_RECOVER;
                            if (w_inc >= w_limit) begin
                                n_mode    = (r_mode == MODE_AVOID) ? MODE_RECOVER : MODE_IDLE;
                                n_elapsed = 16'd0;
                            end else begin
                                n_elapsed = w_inc;
                            end
                        end
                        default: begin
                            n_out_angle    = r_cached_angle;
                            n_out_throttle = r_cached_throttle;
                            n_out_mode     = MODE_CODE_IDLE;
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode            <= MODE_IDLE;
            r_elapsed         <= 16'd0;
            r_steer_left      <= 1'b0;
            r_cached_angle    <= 16'd0;
            r_cached_throttle <= 16'd0;
            r_side            <= 1'b0;
            r_found           <= 1'b0;
            r_out_valid       <= 1'b0;
        end else begin
            r_mode            <= n_mode;
            r_elapsed         <= n_elapsed;
            r_steer_left      <= n_steer_left;
            r_cached_angle    <= n_cached_angle;
            r_cached_throttle <= n_cached_throttle;
            r_side            <= n_side;
            r_found           <= n_found;
            r_out_valid       <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nearest      <= n_nearest;
        r_out_angle    <= n_out_angle;
        r_out_throttle <= n_out_throttle;
        r_out_mode     <= n_out_mode;
    end

endmodule

@@ rtl/obstacle_avoid_steering_mux.sv @@
// A tick item passes both front stages and the queue, then leaves it once the result slot is free.
// Throughput: one item per cycle while the queue is not full, set by the two-stage front
// (squares, then sum and compare) feeding a queue that the back drains one item per cycle.
// Reset: synchronous, active low; it empties the pipeline, queue and result slot, returns
// the mode to idle, clears the cached command and scan state, and restores register defaults.
module obstacle_avoid_steering_mux import oasm_pkg::*; #(
    parameter int COORD_WIDTH = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [1:0]             i_kind,
    input  logic signed [15:0]     i_model_angle,
    input  logic signed [15:0]     i_model_throttle,
    input  logic signed [COORD_WIDTH-1:0] i_obj_x_mm,
    input  logic signed [COORD_WIDTH-1:0] i_obj_y_mm,
    input  logic                   i_last_object,
    output logic                   empty,
    input  logic                   pop,
    output logic signed [15:0]     o_cmd_angle,
    output logic signed [15:0]     o_cmd_throttle,
    output logic [1:0]             o_mode,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [2:0]             i_cfg_index,
    input  logic [15:0]            i_cfg_data
);

    logic [14:0]      r_trigger;
    logic [14:0]      r_window;
    logic [14:0]      r_steer;
    logic [15:0]      r_throttle;
    logic [15:0]      r_avoid_ticks;
    logic [15:0]      r_recover_ticks;
    logic [TSQ_W-1:0] r_tsq;

    t_cfg             w_cfg;
    logic             w_q_push;
    logic             w_q_full;
    logic             w_q_pop;
    logic             w_q_empty;
    t_item            w_front_item;
    t_item            w_q_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger       <= 15'd80;
            r_window        <= 15'd150;
            r_steer         <= 15'd16384;
            r_throttle      <= 16'd8192;
            r_avoid_ticks   <= 16'd50;
            r_recover_ticks <= 16'd25;
            r_tsq           <= TSQ_W'(6400);
        end else begin
            r_tsq <= TSQ_W'(r_trigger) * TSQ_W'(r_trigger);
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TRIGGER:       r_trigger       <= i_cfg_data[14:0];
                    CFG_WINDOW:        r_window        <= i_cfg_data[14:0];
                    CFG_STEER:         r_steer         <= i_cfg_data[14:0];
                    CFG_THROTTLE:      r_throttle      <= i_cfg_data;
                    CFG_AVOID_TICKS:   r_avoid_ticks   <= i_cfg_data;
                    CFG_RECOVER_TICKS: r_recover_ticks <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        w_cfg               = '0;
        w_cfg.steer         = r_steer;
        w_cfg.throttle      = r_throttle;
        w_cfg.avoid_ticks   = r_avoid_ticks;
        w_cfg.recover_ticks = r_recover_ticks;
    end

    oasm_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_kind          (i_kind),
        .i_model_angle   (i_model_angle),
        .i_model_throttle(i_model_throttle),
        .i_obj_x_mm      (i_obj_x_mm),
        .i_obj_y_mm      (i_obj_y_mm),
        .i_last_object   (i_last_object),
        .i_window        (r_window),
        .i_tsq           (r_tsq),
        .o_q_push        (w_q_push),
        .o_q_item        (w_front_item),
        .i_q_full        (w_q_full)
    );

    oasm_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_q_push),
        .i_item (w_front_item),
        .o_full (w_q_full),
        .i_pop  (w_q_pop),
        .o_item (w_q_item),
        .o_empty(w_q_empty)
    );

    oasm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (w_q_empty),
        .i_q_item      (w_q_item),
        .o_q_pop       (w_q_pop),
        .i_cfg         (w_cfg),
        .empty         (empty),
        .pop           (pop),
        .o_cmd_angle   (o_cmd_angle),
        .o_cmd_throttle(o_cmd_throttle),
        .o_mode        (o_mode)
    );

endmodule

@@ rtl/oasm_checker.sv @@
`include "obstacle_avoid_steering_mux_defines.svh"

module oasm_checker import oasm_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input logic signed [15:0] o_cmd_angle,
    input logic signed [15:0] o_cmd_throttle,
    input logic [1:0]         o_mode
);

    `OASM_ASSERT_RESET(a_reset_drains, i_clk, i_rst_n, empty && !full)

    `OASM_ASSERT_IMPLY(a_recover_straight, i_clk, i_rst_n,
        !empty && (o_mode == MODE_CODE_RECOVER), o_cmd_angle == 16'sd0)

    `OASM_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, !empty && !pop,
        !empty && $stable(o_cmd_angle) && $stable(o_cmd_throttle) && $stable(o_mode))

endmodule

bind obstacle_avoid_steering_mux oasm_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .o_cmd_angle   (o_cmd_angle),
    .o_cmd_throttle(o_cmd_throttle),
    .o_mode        (o_mode)
);
